FILE: sv/line_rast_pkg.sv
// Shared types and constants for the Bresenham line rasterizer.
package line_rast_pkg;

  // Width of every signed pixel coordinate.
  localparam int unsigned CoordBits = 12;
  // Width of the screen size registers.
  localparam int unsigned ScreenBits = 11;
  // Width of the configuration register index.
  localparam int unsigned CfgIndexBits = 2;

  // Reset values of the screen size registers.
  localparam logic [ScreenBits-1:0] ScreenWidthReset  = ScreenBits'(240);
  localparam logic [ScreenBits-1:0] ScreenHeightReset = ScreenBits'(320);

  // Input item kinds.
  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_STEP = 1'b1
  } kind_e;

  // Configuration register indexes.
  typedef enum logic [CfgIndexBits-1:0] {
    CFG_SCREEN_WIDTH  = 2'd0,
    CFG_SCREEN_HEIGHT = 2'd1
  } cfg_reg_e;

  // One input item.
  typedef struct packed {
    kind_e                        kind;
    logic signed [CoordBits-1:0]  start_x;
    logic signed [CoordBits-1:0]  start_y;
    logic signed [CoordBits-1:0]  end_x;
    logic signed [CoordBits-1:0]  end_y;
    logic [15:0]                  line_color;
  } line_in_t;

  // One produced pixel.
  typedef struct packed {
    logic signed [CoordBits-1:0]  pixel_x;
    logic signed [CoordBits-1:0]  pixel_y;
    logic [15:0]                  pixel_color;
    logic                         on_screen;
    logic                         last;
  } pixel_out_t;

endpackage

FILE: sv/line_rasterizer_top.sv
// Bresenham line rasterizer: load and step handling with a two-entry result buffer.
//
// Each input transfer is either a load, which sets up a new line from two signed
// endpoints and a color and gives no pixel, or a step, which gives the next pixel
// of the current line (nothing when no line is active). One item is taken every
// clock cycle unless the input is held off: line setup and the per-pixel add,
// compare and select all complete in the cycle of the transfer, and the pixel is
// registered into the output register, or into a second result register behind
// it while the consumer stalls; the input is held off only when both are full.
// Screen width and height are written over the configuration port, which is
// always ready, and should be changed only while the block is idle.
module line_rasterizer_top (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  line_rast_pkg::line_in_t                in_data_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output line_rast_pkg::pixel_out_t              out_data_o,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [line_rast_pkg::CfgIndexBits-1:0] cfg_index_i,
  input  logic [line_rast_pkg::ScreenBits-1:0]   cfg_data_i
);
  import line_rast_pkg::*;

  localparam int unsigned DeltaBits = CoordBits + 1;
  localparam int unsigned ErrBits   = CoordBits + 2;
  localparam int unsigned CmpBits   = (CoordBits > ScreenBits) ? CoordBits : ScreenBits;

  // Screen size registers.
  logic [ScreenBits-1:0] screen_width_q, screen_height_q;

  // Line state.
  logic signed [CoordBits-1:0] major_pos_q, major_pos_d;
  logic signed [CoordBits-1:0] minor_pos_q, minor_pos_d;
  logic signed [CoordBits-1:0] major_end_q, major_end_d;
  logic [DeltaBits-1:0]        major_delta_q, major_delta_d;
  logic [DeltaBits-1:0]        minor_delta_q, minor_delta_d;
  logic signed [ErrBits-1:0]   error_q, error_d;
  logic                        dir_neg_q, dir_neg_d;
  logic                        steep_q, steep_d;
  logic                        active_q, active_d;
  logic [15:0]                 color_q, color_d;

  // Result buffer: output register plus one skid entry.
  logic       out_valid_q, skid_valid_q;
  pixel_out_t out_q, skid_q;

  logic in_fire, out_fire, is_step, res_valid;
  pixel_out_t res;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !skid_valid_q;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_fire    = out_valid_q && out_ready_i;
  assign is_step     = (in_data_i.kind == KIND_STEP);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_width_q  <= ScreenWidthReset;
      screen_height_q <= ScreenHeightReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_SCREEN_WIDTH:  screen_width_q  <= cfg_data_i;
        CFG_SCREEN_HEIGHT: screen_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Line setup for a load: steepness, endpoint order, deltas and direction.
  logic signed [DeltaBits-1:0] dx, dy, maj_diff, min_diff;
  logic [DeltaBits-1:0]        adx, ady;
  logic                        ld_steep, ld_swap;
  logic signed [CoordBits-1:0] s_maj, s_min, e_maj, e_min;
  logic signed [CoordBits-1:0] a_maj, a_min, b_maj, b_min;

  always_comb begin
    dx  = DeltaBits'(in_data_i.end_x) - DeltaBits'(in_data_i.start_x);
    dy  = DeltaBits'(in_data_i.end_y) - DeltaBits'(in_data_i.start_y);
    adx = dx[DeltaBits-1] ? DeltaBits'(-dx) : DeltaBits'(dx);
    ady = dy[DeltaBits-1] ? DeltaBits'(-dy) : DeltaBits'(dy);
    ld_steep = ady > adx;
    s_maj = ld_steep ? in_data_i.start_y : in_data_i.start_x;
    s_min = ld_steep ? in_data_i.start_x : in_data_i.start_y;
    e_maj = ld_steep ? in_data_i.end_y   : in_data_i.end_x;
    e_min = ld_steep ? in_data_i.end_x   : in_data_i.end_y;
    ld_swap = s_maj > e_maj;
    a_maj = ld_swap ? e_maj : s_maj;
    a_min = ld_swap ? e_min : s_min;
    b_maj = ld_swap ? s_maj : e_maj;
    b_min = ld_swap ? s_min : e_min;
    maj_diff = DeltaBits'(b_maj) - DeltaBits'(a_maj);
    min_diff = DeltaBits'(b_min) - DeltaBits'(a_min);
  end

  // Pixel for a step: position, clipping and end of line.
  logic signed [CoordBits-1:0] px, py;
  logic [CmpBits-1:0]          px_ext, py_ext, w_ext, h_ext;
  logic                        fin;
  logic signed [ErrBits-1:0]   err_sub;

  always_comb begin
    px = steep_q ? minor_pos_q : major_pos_q;
    py = steep_q ? major_pos_q : minor_pos_q;
    px_ext = CmpBits'(unsigned'(px));
    py_ext = CmpBits'(unsigned'(py));
    w_ext  = CmpBits'(screen_width_q);
    h_ext  = CmpBits'(screen_height_q);
    fin     = major_pos_q >= major_end_q;
    err_sub = error_q - signed'(ErrBits'(minor_delta_q));

    res.pixel_x     = px;
    res.pixel_y     = py;
    res.pixel_color = color_q;
    res.on_screen   = !px[CoordBits-1] && (px_ext < w_ext) &&
                      !py[CoordBits-1] && (py_ext < h_ext);
    res.last        = fin;
    res_valid       = in_fire && is_step && active_q;
  end

  // Next line state.
  always_comb begin
    major_pos_d   = major_pos_q;
    minor_pos_d   = minor_pos_q;
    major_end_d   = major_end_q;
    major_delta_d = major_delta_q;
    minor_delta_d = minor_delta_q;
    error_d       = error_q;
    dir_neg_d     = dir_neg_q;
    steep_d       = steep_q;
    active_d      = active_q;
    color_d       = color_q;
    if (in_fire && !is_step) begin
      major_pos_d   = a_maj;
      minor_pos_d   = a_min;
      major_end_d   = b_maj;
      major_delta_d = DeltaBits'(maj_diff);
      minor_delta_d = min_diff[DeltaBits-1] ? DeltaBits'(-min_diff) : DeltaBits'(min_diff);
      error_d       = signed'(ErrBits'(DeltaBits'(maj_diff) >> 1));
      dir_neg_d     = !(a_min < b_min);
      steep_d       = ld_steep;
      active_d      = 1'b1;
      color_d       = in_data_i.line_color;
    end else if (res_valid) begin
      if (fin) begin
        active_d = 1'b0;
      end else begin
        major_pos_d = major_pos_q + CoordBits'(1);
        if (err_sub[ErrBits-1]) begin
          minor_pos_d = dir_neg_q ? minor_pos_q - CoordBits'(1) : minor_pos_q + CoordBits'(1);
          error_d     = err_sub + signed'(ErrBits'(major_delta_q));
        end else begin
          error_d = err_sub;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      major_pos_q   <= '0;
      minor_pos_q   <= '0;
      major_end_q   <= '0;
      major_delta_q <= '0;
      minor_delta_q <= '0;
      error_q       <= '0;
      dir_neg_q     <= 1'b0;
      steep_q       <= 1'b0;
      active_q      <= 1'b0;
      color_q       <= '0;
    end else begin
      major_pos_q   <= major_pos_d;
      minor_pos_q   <= minor_pos_d;
      major_end_q   <= major_end_d;
      major_delta_q <= major_delta_d;
      minor_delta_q <= minor_delta_d;
      error_q       <= error_d;
      dir_neg_q     <= dir_neg_d;
      steep_q       <= steep_d;
      active_q      <= active_d;
      color_q       <= color_d;
    end
  end

  // Result buffer control; the skid entry always drains first to keep order.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_valid_q && !out_fire) begin
      if (res_valid) begin
        skid_valid_q <= 1'b1;
      end
    end else if (skid_valid_q) begin
      out_valid_q  <= 1'b1;
      skid_valid_q <= res_valid;
    end else begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_valid_q && !out_fire) begin
      if (res_valid) begin
        skid_q <= res;
      end
    end else if (skid_valid_q) begin
      out_q <= skid_q;
      if (res_valid) begin
        skid_q <= res;
      end
    end else if (res_valid) begin
      out_q <= res;
    end
  end

  // The skid entry is only ever filled behind a held output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry valid without an output result");

  // A step on an active line always leaves a valid output result in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |=> out_valid_q)
    else $error("step on active line gave no result");

  // The final pixel ends the line.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && fin) |=> !active_q)
    else $error("line still active after its last pixel");

  // A load always starts a line.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !is_step) |=> active_q)
    else $error("load did not start a line");

  // The error term stays non-negative between steps.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> !error_q[ErrBits-1])
    else $error("error term negative on an active line");

endmodule
